// File: hw/rtl/voxel_ray_traversal_unit_macros.svh
// Assertion helpers for the voxel ray traversal unit.
`ifndef VOXEL_RAY_TRAVERSAL_UNIT_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define VRT_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication check failed");
`define VRT_ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
		else $error("forbidden condition seen");
`else
`define VRT_ASSERT_IMPL(label, clk, rst_n, a, c)
`define VRT_ASSERT_NEVER(label, clk, rst_n, a)
`endif

`endif

// File: hw/rtl/vrt_pkg.sv
package vrt_pkg;

	localparam logic [31:0] TINF = 32'hFFFF_FFFF;
	localparam int FRAC_MAX = 24;
	localparam int QDEPTH = 2;

	localparam logic [1:0] KIND_QUERY  = 2'd0;
	localparam logic [1:0] KIND_HIT    = 2'd1;
	localparam logic [1:0] KIND_MISS   = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	typedef enum logic [1:0] {
		CLS_START,
		CLS_ANSWER,
		CLS_REJECT
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AXIS,
		ST_DIV,
		ST_SQRT,
		ST_MUL,
		ST_NEXT,
		ST_EMIT
	} st_t;

	typedef struct packed {
		cls_t                         cls;
		logic [2:0][31:0]             voxel;
		logic [2:0][FRAC_MAX-1:0]     frac;
		logic [2:0]                   d_pos;
		logic [2:0]                   d_zero;
		logic [2:0][30:0]             d2;
		logic [31:0]                  n2;
		logic [31:0]                  reach;
		logic                         present;
		logic                         solid;
		logic [15:0]                  block;
	} item_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} fifo_stat_t;

endpackage

// File: hw/rtl/vrt_front.sv
module vrt_front import vrt_pkg::*; #(
	parameter int COORD_INT_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic             command,
	input  logic [2:0][47:0] origin,
	input  logic [2:0][15:0] dir,
	input  logic [31:0]      reach,
	input  logic             chunk_present,
	input  logic             solid,
	input  logic [15:0]      block_id,
	output item_t            item
);

	localparam int OW = (COORD_INT_BITS + FRAC_BITS > 64) ? 64 : COORD_INT_BITS + FRAC_BITS;
	localparam int SH = 72 - OW;

	always_comb begin
		logic [71:0] raw;
		logic signed [71:0] osx;
		logic signed [71:0] fl;
		logic signed [31:0] sq;
		logic [31:0] n2s;
		n2s = '0;
		item = '0;
		for (int a = 0; a < 3; a++) begin
			// sign bit sits at the top of the coordinate word
			raw = {24'b0, origin[a]};
			osx = $signed(raw << SH) >>> SH;
			fl = osx >>> FRAC_BITS;
			item.voxel[a] = fl[31:0];
			item.frac[a] = FRAC_MAX'(osx[FRAC_BITS-1:0]);
			sq = $signed(dir[a]) * $signed(dir[a]);
			item.d2[a] = sq[30:0];
			n2s = n2s + 32'(unsigned'(sq));
			item.d_zero[a] = (dir[a] == 16'd0);
			item.d_pos[a] = !dir[a][15] && (dir[a] != 16'd0);
		end
		item.n2 = n2s;
		item.reach = reach;
		item.present = chunk_present;
		item.solid = solid;
		item.block = block_id;
		if (command) begin
			item.cls = CLS_ANSWER;
		end else if (n2s == 32'd0) begin
			item.cls = CLS_REJECT;
		end else begin
			item.cls = CLS_START;
		end
	end

endmodule

// File: hw/rtl/vrt_fifo.sv
module vrt_fifo import vrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output item_t      out_item,
	output fifo_stat_t stat
);

	item_t      mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign out_valid = (cnt_q != 2'd0);
	assign out_item = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign stat.count = cnt_q;
	assign stat.full = !in_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hw/rtl/vrt_back.sv
module vrt_back import vrt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  item_t            in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [2:0][31:0] voxel,
	output logic [2:0][1:0]  normal,
	output logic [31:0]      distance,
	output logic [15:0]      hit_block
);

	localparam int NW = 32 + 2 * FRAC_BITS;

	st_t state_q, state_n;
	item_t ent_q;
	logic [1:0] axis_q;
	logic [6:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [32:0] rem_q;
	logic [63:0] sq_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic inf_q;

	logic busy_q, at_origin_q;
	logic [2:0][31:0] vox_q;
	logic [2:0] pos_q, zero_q;
	logic [2:0][31:0] bt_q, td_q;
	logic [31:0] trav_q, reach_q;
	logic [2:0][1:0] norm_q;

	logic out_free;
	logic out_load;
	logic [1:0] kind_n;
	logic [2:0][31:0] voxel_n;
	logic [2:0][1:0] normal_n;
	logic [31:0] dist_n;
	logic [15:0] block_n;

	// traversal step
	logic [1:0] sel;
	logic [31:0] bt_sel, td_sel, bt_new;
	logic [32:0] bt_sum;
	logic [2:0][31:0] vox_step;
	logic [2:0][1:0] norm_step;
	logic step_miss;
	logic hit;

	// divider, root and boundary datapath
	logic [32:0] div_r;
	logic div_ge;
	logic [NW-1:0] num_n;
	logic [79:0] quo_ext;
	logic [33:0] srem_t, trial;
	logic sq_ge;
	logic [FRAC_BITS:0] bdist;
	logic [31:0] delta;
	logic [FRAC_BITS+32:0] prod;
	logic [31:0] bt_init;

	assign out_free = !out_valid || out_ready;
	assign hit = in_item.present && in_item.solid;

	always_comb begin
		if (bt_q[0] < bt_q[1] && bt_q[0] < bt_q[2]) begin
			sel = 2'd0;
		end else if (bt_q[1] < bt_q[2]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
		bt_sel = bt_q[sel];
		td_sel = td_q[sel];
		bt_sum = {1'b0, bt_sel} + {1'b0, td_sel};
		bt_new = (bt_sel == TINF || td_sel == TINF || bt_sum[32]) ? TINF : bt_sum[31:0];
		vox_step = vox_q;
		norm_step = '0;
		if (!zero_q[sel]) begin
			vox_step[sel] = pos_q[sel] ? vox_q[sel] + 32'd1 : vox_q[sel] - 32'd1;
			norm_step[sel] = pos_q[sel] ? 2'b11 : 2'b01;
		end
		step_miss = (bt_sel == TINF) || (bt_sel > reach_q);
	end

	always_comb begin
		div_r = {rem_q[31:0], num_q[NW-1]};
		div_ge = div_r >= {2'b0, ent_q.d2[axis_q]};
		num_n = {num_q[NW-2:0], div_ge};
		quo_ext = 80'(num_n);
		srem_t = {srem_q[31:0], sq_q[63:62]};
		trial = {root_q, 2'b01};
		sq_ge = srem_t >= trial;
		bdist = pos_q[axis_q]
			? ((FRAC_BITS+1)'(1) << FRAC_BITS)
				- (FRAC_BITS+1)'(ent_q.frac[axis_q][FRAC_BITS-1:0])
			: (FRAC_BITS+1)'(ent_q.frac[axis_q][FRAC_BITS-1:0]);
		delta = inf_q ? TINF : root_q;
		prod = (FRAC_BITS+33)'(bdist) * (FRAC_BITS+33)'(delta);
		if (inf_q) begin
			bt_init = (bdist != '0) ? TINF : 32'd0;
		end else begin
			bt_init = prod[FRAC_BITS+31:FRAC_BITS];
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && out_free && in_item.cls == CLS_START) state_n = ST_AXIS;
			end
			ST_AXIS: state_n = ent_q.d_zero[axis_q] ? ST_NEXT : ST_DIV;
			ST_DIV:  state_n = (cnt_q == 7'(NW - 1)) ? ST_SQRT : ST_DIV;
			ST_SQRT: state_n = (cnt_q == 7'd31) ? ST_MUL : ST_SQRT;
			ST_MUL:  state_n = ST_NEXT;
			ST_NEXT: state_n = (axis_q == 2'd2) ? ST_EMIT : ST_AXIS;
			ST_EMIT: state_n = out_free ? ST_IDLE : ST_EMIT;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		kind_n = KIND_QUERY;
		voxel_n = '0;
		normal_n = '0;
		dist_n = '0;
		block_n = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					unique case (in_item.cls)
						CLS_REJECT: begin
							out_load = 1'b1;
							kind_n = KIND_REJECT;
						end
						CLS_ANSWER: begin
							out_load = busy_q;
							if (hit) begin
								kind_n = KIND_HIT;
								voxel_n = vox_q;
								normal_n = at_origin_q ? '0 : norm_q;
								dist_n = at_origin_q ? 32'd0 : trav_q;
								block_n = in_item.block;
							end else if (step_miss) begin
								kind_n = KIND_MISS;
							end else begin
								voxel_n = vox_step;
							end
						end
						default: ;
					endcase
				end
			end
			ST_EMIT: begin
				out_load = out_free;
				voxel_n = vox_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			at_origin_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_IDLE && in_valid && out_free) begin
				unique case (in_item.cls)
					CLS_START: begin
						busy_q <= 1'b1;
						at_origin_q <= 1'b1;
					end
					CLS_REJECT: busy_q <= 1'b0;
					CLS_ANSWER: begin
						if (busy_q) begin
							at_origin_q <= 1'b0;
							if (hit || step_miss) busy_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && out_free) begin
					if (in_item.cls == CLS_START) begin
						ent_q <= in_item;
						vox_q <= in_item.voxel;
						pos_q <= in_item.d_pos;
						zero_q <= in_item.d_zero;
						trav_q <= 32'd0;
						reach_q <= in_item.reach;
						norm_q <= '0;
						axis_q <= 2'd0;
					end else if (in_item.cls == CLS_ANSWER && busy_q && !hit) begin
						vox_q <= vox_step;
						trav_q <= bt_sel;
						bt_q[sel] <= bt_new;
						norm_q <= norm_step;
					end
				end
			end
			ST_AXIS: begin
				if (ent_q.d_zero[axis_q]) begin
					td_q[axis_q] <= TINF;
					bt_q[axis_q] <= TINF;
				end
				cnt_q <= 7'd0;
				num_q <= NW'({ent_q.n2, {(2*FRAC_BITS){1'b0}}});
				rem_q <= 33'd0;
			end
			ST_DIV: begin
				num_q <= num_n;
				rem_q <= div_ge ? div_r - {2'b0, ent_q.d2[axis_q]} : div_r;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(NW - 1)) begin
					// quotient past 64 bits saturates the delta
					sq_q <= quo_ext[63:0];
					inf_q <= |quo_ext[79:64];
					cnt_q <= 7'd0;
					srem_q <= 34'd0;
					root_q <= 32'd0;
				end
			end
			ST_SQRT: begin
				sq_q <= {sq_q[61:0], 2'b00};
				srem_q <= sq_ge ? srem_t - trial : srem_t;
				root_q <= {root_q[30:0], sq_ge};
				cnt_q <= cnt_q + 7'd1;
			end
			ST_MUL: begin
				td_q[axis_q] <= delta;
				bt_q[axis_q] <= bt_init;
			end
			ST_NEXT: begin
				if (axis_q != 2'd2) axis_q <= axis_q + 2'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind <= kind_n;
			voxel <= voxel_n;
			normal <= normal_n;
			distance <= dist_n;
			hit_block <= block_n;
		end
	end

endmodule

// File: hw/rtl/voxel_ray_traversal_unit.sv
// Answer request: taken by the back end in its idle state, result registered as it is taken.
// Start request: per moving axis one bit-serial divide (32 + 2*FRAC_BITS quotient bits),
// a bit-serial 32-bit root and a multiply.
// A two-entry queue lets requests enter while the back end or output is busy.
// Reset (arst_n low, asynchronous) clears control: queue, state, busy, output valid.
`include "voxel_ray_traversal_unit_macros.svh"

module voxel_ray_traversal_unit import vrt_pkg::*; #(
	parameter int COORD_INT_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, reach,
	// chunk_present, solid, block_id, zero pad
	input  logic [247:0] s_axis_tdata,
	// command
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// voxel_x, voxel_y, voxel_z, normal_x, normal_y, normal_z,
	// distance, hit_block, zero pad
	output logic [151:0] m_axis_tdata,
	// kind
	output logic [1:0]   m_axis_tuser
);

	item_t fr_item, q_item;
	logic q_valid, q_ready;
	fifo_stat_t q_stat;
	logic [2:0][31:0] voxel;
	logic [2:0][1:0] normal;
	logic [31:0] distance;
	logic [15:0] hit_block;

	vrt_front #(
		.COORD_INT_BITS(COORD_INT_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.command      (s_axis_tuser),
		.origin       ({s_axis_tdata[143:96], s_axis_tdata[95:48], s_axis_tdata[47:0]}),
		.dir          ({s_axis_tdata[191:176], s_axis_tdata[175:160], s_axis_tdata[159:144]}),
		.reach        (s_axis_tdata[223:192]),
		.chunk_present(s_axis_tdata[224]),
		.solid        (s_axis_tdata[225]),
		.block_id     (s_axis_tdata[241:226]),
		.item         (fr_item)
	);

	vrt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (fr_item),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_item (q_item),
		.stat     (q_stat)
	);

	vrt_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.kind     (m_axis_tuser),
		.voxel    (voxel),
		.normal   (normal),
		.distance (distance),
		.hit_block(hit_block)
	);

	assign m_axis_tdata = {2'b00, hit_block, distance, normal[2], normal[1], normal[0],
		voxel[2], voxel[1], voxel[0]};

	`VRT_ASSERT_NEVER(a_queue_bound, clk, arst_n, q_stat.count > 2'(QDEPTH))
	`VRT_ASSERT_IMPL(a_full_stalls, clk, arst_n, q_stat.full, !s_axis_tready)
	`VRT_ASSERT_IMPL(a_nonhit_clean, clk, arst_n,
		m_axis_tvalid && m_axis_tuser != KIND_HIT, m_axis_tdata[149:96] == 54'd0)

endmodule
